// ===== hdl/cme_pkg.sv =====
// Package for the community move engine: request/response structs,
// tally chain control types, field widths and default parameter values.
// No dependencies.
`default_nettype none
package cme_pkg;

   localparam int ID_BITS  = 12;
   localparam int DEG_BITS = 16;
   localparam int CNT_BITS = 16;
   localparam int TW_BITS  = 32;
   localparam int OUT_W    = 32;

   localparam int DEF_MAX_NODES       = 4096;
   localparam int DEF_MAX_COMMUNITIES = 64;
   localparam int DEF_WEIGHT_BITS     = 32;

   localparam logic [TW_BITS-1:0] TW_RESET = TW_BITS'(1);

   localparam logic CMD_INIT = 1'b0;
   localparam logic CMD_MOVE = 1'b1;

   typedef struct packed {
      logic                command;
      logic [ID_BITS-1:0]  node;
      logic [DEG_BITS-1:0] degree;
      logic [DEG_BITS-1:0] self_loops;
      logic [ID_BITS-1:0]  neighbour;
      logic                neighbour_valid;
      logic                last;
   } req_type;

   typedef struct packed {
      logic [ID_BITS-1:0] moved_node;
      logic [ID_BITS-1:0] old_community;
      logic [ID_BITS-1:0] new_community;
      logic               moved;
      logic [OUT_W-1:0]   new_total;
      logic [OUT_W-1:0]   new_internal;
      logic               tally_overflow;
   } rsp_type;

   // control from the sequencer to the tally chain
   typedef struct packed {
      logic clear;
      logic search;
      logic pop;
   } tally_ctl_type;

   // status from the tally chain back to the sequencer
   typedef struct packed {
      logic head_valid;
      logic hit_any;
      logic full;
   } tally_stat_type;

endpackage
`default_nettype wire

// ===== hdl/cme_tally_cell.sv =====
// One cell of the neighbour tally chain: a community id, a saturating count
// and a valid bit. Shifts toward the tail on insert, toward the head on pop.
// Depends on cme_pkg.
`default_nettype none
module cme_tally_cell #(
   parameter int CW = 12
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire cme_pkg::tally_ctl_type       ctl,
   input  wire logic                         insert,
   input  wire logic [CW-1:0]                comm_in,
   input  wire logic                         left_valid,
   input  wire logic [CW-1:0]                left_comm,
   input  wire logic [cme_pkg::CNT_BITS-1:0] left_count,
   input  wire logic                         right_valid,
   input  wire logic [CW-1:0]                right_comm,
   input  wire logic [cme_pkg::CNT_BITS-1:0] right_count,
   output logic                              valid,
   output logic [CW-1:0]                     comm,
   output logic [cme_pkg::CNT_BITS-1:0]      count,
   output logic                              hit
);
   import cme_pkg::*;

   logic                valid_ff, valid_in;
   logic [CW-1:0]       comm_ff, comm_in_nxt;
   logic [CNT_BITS-1:0] count_ff, count_in;

   assign hit = valid_ff && (comm_ff == comm_in);

   always_comb begin
      valid_in    = valid_ff;
      comm_in_nxt = comm_ff;
      count_in    = count_ff;
      if (ctl.clear) begin
         valid_in = 1'b0;
      end else if (ctl.pop) begin
         valid_in    = right_valid;
         comm_in_nxt = right_comm;
         count_in    = right_count;
      end else if (insert) begin
         valid_in    = left_valid;
         comm_in_nxt = left_comm;
         count_in    = left_count;
      end else if (ctl.search && hit && (count_ff != '1)) begin
         count_in = count_ff + CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      comm_ff  <= comm_in_nxt;
      count_ff <= count_in;
   end

   assign valid = valid_ff;
   assign comm  = comm_ff;
   assign count = count_ff;

endmodule
`default_nettype wire

// ===== hdl/cme_tally_chain.sv =====
// Row of tally cells holding the distinct neighbour communities of a move.
// New entries enter at the head; the walk pops entries out of the head.
// Depends on cme_pkg and cme_tally_cell.
`default_nettype none
module cme_tally_chain #(
   parameter int N  = cme_pkg::DEF_MAX_COMMUNITIES,
   parameter int CW = 12
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire cme_pkg::tally_ctl_type       ctl,
   input  wire logic [CW-1:0]                comm_in,
   output cme_pkg::tally_stat_type           stat,
   output logic [CW-1:0]                     head_comm,
   output logic [cme_pkg::CNT_BITS-1:0]      head_count
);
   import cme_pkg::*;

   logic                valid [N];
   logic [CW-1:0]       comm  [N];
   logic [CNT_BITS-1:0] count [N];
   logic [N-1:0]        hit;
   logic                insert;

   assign stat.hit_any    = |hit;
   assign stat.full       = valid[N-1];
   assign stat.head_valid = valid[0];
   assign insert          = ctl.search && !stat.hit_any && !stat.full;
   assign head_comm       = comm[0];
   assign head_count      = count[0];

   for (genvar i = 0; i < N; i++) begin : g_cell
      logic                lv, rv;
      logic [CW-1:0]       lc, rc;
      logic [CNT_BITS-1:0] ln, rn;
      if (i == 0) begin : g_head
         assign lv = 1'b1;
         assign lc = comm_in;
         assign ln = CNT_BITS'(1);
      end else begin : g_mid
         assign lv = valid[i-1];
         assign lc = comm[i-1];
         assign ln = count[i-1];
      end
      if (i == N-1) begin : g_tail
         assign rv = 1'b0;
         assign rc = '0;
         assign rn = '0;
      end else begin : g_body
         assign rv = valid[i+1];
         assign rc = comm[i+1];
         assign rn = count[i+1];
      end
      cme_tally_cell #(.CW(CW)) u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .insert      (insert),
         .comm_in     (comm_in),
         .left_valid  (lv),
         .left_comm   (lc),
         .left_count  (ln),
         .right_valid (rv),
         .right_comm  (rc),
         .right_count (rn),
         .valid       (valid[i]),
         .comm        (comm[i]),
         .count       (count[i]),
         .hit         (hit[i])
      );
   end

endmodule
`default_nettype wire

// ===== hdl/community_move_engine_core.sv =====
// Top level of the community move engine: node/community memories,
// move sequencer, gain evaluation and the response register.
// Depends on cme_pkg and cme_tally_chain.
//
//  channel | dir | handshake                 | payload
//  req     | in  | req_valid / req_stall     | req_data  (cme_pkg::req_type)
//  rsp     | out | rsp_valid / rsp_stall     | rsp_data  (cme_pkg::rsp_type)
//  csr     | in  | csr_wr_en (no wait)       | csr_wr_data (total_weight)
//
// Sequencing: an init request writes all three memories at once. A neighbour
// request whose neighbour is tallied adds a community memory read. The last
// request of a move then walks the tally chain, where each tallied entry
// needs a community_total read, a multiply stage and a compare stage.
// Reset: synchronous, active high; clears control state, the tally valid
// bits and total_weight (to 1). Node and community memories are not cleared.
// Stalls: req_stall is high whenever the sequencer is busy. A response
// held by rsp_stall blocks only the final write-back of the next move.
`default_nettype none
module community_move_engine_core #(
   parameter int MAX_NODES                = cme_pkg::DEF_MAX_NODES,
   parameter int MAX_COMMUNITIES_PER_NODE = cme_pkg::DEF_MAX_COMMUNITIES,
   parameter int WEIGHT_BITS              = cme_pkg::DEF_WEIGHT_BITS
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_valid,
   output logic                               req_stall,
   input  wire cme_pkg::req_type              req_data,
   output logic                               rsp_valid,
   input  wire logic                          rsp_stall,
   output cme_pkg::rsp_type                   rsp_data,
   input  wire logic                          csr_wr_en,
   input  wire logic [cme_pkg::TW_BITS-1:0]   csr_wr_data
);
   import cme_pkg::*;

   localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int W  = WEIGHT_BITS;
   // gain = count*total_weight - total*degree, wide enough for both products
   localparam int GW = ((W > TW_BITS) ? W : TW_BITS) + CNT_BITS;

   // sequencer states
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_TALLY = 4'd1;
   localparam logic [3:0] S_OLD   = 4'd2;
   localparam logic [3:0] S_OLDC  = 4'd3;
   localparam logic [3:0] S_REM   = 4'd4;
   localparam logic [3:0] S_WRD   = 4'd5;
   localparam logic [3:0] S_WMUL  = 4'd6;
   localparam logic [3:0] S_WCMP  = 4'd7;
   localparam logic [3:0] S_FA    = 4'd8;
   localparam logic [3:0] S_FB    = 4'd9;
   localparam logic [3:0] S_FC    = 4'd10;
   localparam logic [3:0] S_FD    = 4'd11;

   // node id modulo MAX_NODES by restoring subtraction of shifted divisor
   function automatic logic [AW-1:0] id_reduce(input logic [ID_BITS-1:0] v);
      logic [31:0] r;
      r = 32'(v);
      for (int k = ID_BITS-1; k >= 0; k--) begin
         if (r >= (32'(MAX_NODES) << k)) begin
            r = r - (32'(MAX_NODES) << k);
         end
      end
      return AW'(r);
   endfunction

   // ---------------------------------------------------------------------
   // memories: node -> community, community totals, community internals
   // ---------------------------------------------------------------------
   logic [AW-1:0] comm_mem [MAX_NODES];
   logic [W-1:0]  tot_mem  [MAX_NODES];
   logic [W-1:0]  int_mem  [MAX_NODES];

   logic          comm_we, comm_re, tot_we, tot_re, int_we, int_re;
   logic [AW-1:0] comm_wa, comm_ra, tot_wa, tot_ra, int_wa, int_ra;
   logic [AW-1:0] comm_wd;
   logic [W-1:0]  tot_wd, int_wd;
   logic [AW-1:0] comm_rd_ff;
   logic [W-1:0]  tot_rd_ff, int_rd_ff;

   always_ff @(posedge clock) begin
      if (comm_we) begin
         comm_mem[comm_wa] <= comm_wd;
      end
      if (comm_re) begin
         comm_rd_ff <= comm_mem[comm_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (tot_we) begin
         tot_mem[tot_wa] <= tot_wd;
      end
      if (tot_re) begin
         tot_rd_ff <= tot_mem[tot_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (int_we) begin
         int_mem[int_wa] <= int_wd;
      end
      if (int_re) begin
         int_rd_ff <= int_mem[int_ra];
      end
   end

   // ---------------------------------------------------------------------
   // tally chain
   // ---------------------------------------------------------------------
   tally_ctl_type       tctl;
   tally_stat_type      tstat;
   logic [AW-1:0]       head_comm;
   logic [CNT_BITS-1:0] head_count;

   cme_tally_chain #(.N(MAX_COMMUNITIES_PER_NODE), .CW(AW)) u_chain (
      .clock      (clock),
      .reset      (reset),
      .ctl        (tctl),
      .comm_in    (comm_rd_ff),
      .stat       (tstat),
      .head_comm  (head_comm),
      .head_count (head_count)
   );

   // ---------------------------------------------------------------------
   // registers
   // ---------------------------------------------------------------------
   logic [3:0]          state_ff, state_in;
   logic [TW_BITS-1:0]  tw_ff, tw_in;
   logic [AW-1:0]       n_ff, n_in;
   logic [DEG_BITS-1:0] deg_ff, deg_in, self_ff, self_in;
   logic                last_ff, last_in;
   logic [AW-1:0]       oldc_ff, oldc_in, best_ff, best_in, c_ff, c_in;
   logic                have_ff, have_in;
   logic [GW-1:0]       bg_ff, bg_in, p_ff, p_in, q_ff, q_in;
   logic [CNT_BITS-1:0] bl_ff, bl_in, lo_ff, lo_in, cnt_ff, cnt_in;
   logic                ovf_ff, ovf_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_ff, rsp_in;

   logic          req_acc;
   logic [AW-1:0] req_n, req_nb;
   logic [GW-1:0] gain;
   logic          better;
   logic [W-1:0]  new_tot, new_int, rem_int;
   logic          rsp_free;

   assign req_stall = (state_ff != S_IDLE);
   assign req_acc   = req_valid && !req_stall;
   assign req_n     = id_reduce(req_data.node);
   assign req_nb    = id_reduce(req_data.neighbour);
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // strictly positive gain; larger gain wins, equal gain keeps lower id
   assign gain   = p_ff - q_ff;
   assign better = (p_ff > q_ff) &&
                   (!have_ff || (gain > bg_ff) || ((gain == bg_ff) && (c_ff < best_ff)));

   // removal takes 2*links_old + self loops out of the old community
   assign rem_int = int_rd_ff - (W'({lo_ff, 1'b0}) + W'(self_ff));
   assign new_tot = tot_rd_ff + W'(deg_ff);
   assign new_int = int_rd_ff + W'({bl_ff, 1'b0}) + W'(self_ff);

   always_comb begin
      state_in = state_ff;
      tw_in    = csr_wr_en ? csr_wr_data : tw_ff;
      n_in     = n_ff;
      deg_in   = deg_ff;
      self_in  = self_ff;
      last_in  = last_ff;
      oldc_in  = oldc_ff;
      best_in  = best_ff;
      c_in     = c_ff;
      have_in  = have_ff;
      bg_in    = bg_ff;
      p_in     = p_ff;
      q_in     = q_ff;
      bl_in    = bl_ff;
      lo_in    = lo_ff;
      cnt_in   = cnt_ff;
      ovf_in   = ovf_ff;
      rsp_in   = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      comm_we = 1'b0; comm_re = 1'b0; comm_wa = '0; comm_ra = '0; comm_wd = '0;
      tot_we  = 1'b0; tot_re  = 1'b0; tot_wa  = '0; tot_ra  = '0; tot_wd  = '0;
      int_we  = 1'b0; int_re  = 1'b0; int_wa  = '0; int_ra  = '0; int_wd  = '0;
      tctl    = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               if (req_data.command == CMD_INIT) begin
                  comm_we = 1'b1; comm_wa = req_n; comm_wd = req_n;
                  tot_we  = 1'b1; tot_wa  = req_n; tot_wd  = W'(req_data.degree);
                  int_we  = 1'b1; int_wa  = req_n; int_wd  = W'(req_data.self_loops);
               end else begin
                  n_in    = req_n;
                  deg_in  = req_data.degree;
                  self_in = req_data.self_loops;
                  last_in = req_data.last;
                  if (req_data.neighbour_valid && (req_nb != req_n)) begin
                     comm_re  = 1'b1;
                     comm_ra  = req_nb;
                     state_in = S_TALLY;
                  end else if (req_data.last) begin
                     state_in = S_OLD;
                  end
               end
            end
         end
         S_TALLY: begin
            tctl.search = 1'b1;
            if (!tstat.hit_any && tstat.full) begin
               ovf_in = 1'b1;
            end
            state_in = last_ff ? S_OLD : S_IDLE;
         end
         S_OLD: begin
            comm_re  = 1'b1;
            comm_ra  = n_ff;
            state_in = S_OLDC;
         end
         S_OLDC: begin
            oldc_in  = comm_rd_ff;
            tot_re   = 1'b1;
            tot_ra   = comm_rd_ff;
            state_in = S_REM;
         end
         S_REM: begin
            tot_we   = 1'b1;
            tot_wa   = oldc_ff;
            tot_wd   = tot_rd_ff - W'(deg_ff);
            best_in  = oldc_ff;
            have_in  = 1'b0;
            bl_in    = '0;
            lo_in    = '0;
            state_in = S_WRD;
         end
         S_WRD: begin
            if (tstat.head_valid) begin
               c_in     = head_comm;
               cnt_in   = head_count;
               tctl.pop = 1'b1;
               tot_re   = 1'b1;
               tot_ra   = head_comm;
               state_in = S_WMUL;
            end else begin
               state_in = S_FA;
            end
         end
         S_WMUL: begin
            p_in = GW'(cnt_ff) * GW'(tw_ff);
            q_in = GW'(tot_rd_ff) * GW'(deg_ff);
            if (c_ff == oldc_ff) begin
               lo_in = cnt_ff;
            end
            state_in = S_WCMP;
         end
         S_WCMP: begin
            if (better) begin
               have_in = 1'b1;
               best_in = c_ff;
               bg_in   = gain;
               bl_in   = cnt_ff;
            end
            state_in = S_WRD;
         end
         S_FA: begin
            int_re   = 1'b1;
            int_ra   = oldc_ff;
            state_in = S_FB;
         end
         S_FB: begin
            int_we   = 1'b1;
            int_wa   = oldc_ff;
            int_wd   = rem_int;
            state_in = S_FC;
         end
         S_FC: begin
            tot_re   = 1'b1;
            tot_ra   = best_ff;
            int_re   = 1'b1;
            int_ra   = best_ff;
            state_in = S_FD;
         end
         S_FD: begin
            if (rsp_free) begin
               tot_we  = 1'b1; tot_wa  = best_ff; tot_wd  = new_tot;
               int_we  = 1'b1; int_wa  = best_ff; int_wd  = new_int;
               comm_we = 1'b1; comm_wa = n_ff;    comm_wd = best_ff;
               rsp_in.moved_node     = ID_BITS'(n_ff);
               rsp_in.old_community  = ID_BITS'(oldc_ff);
               rsp_in.new_community  = ID_BITS'(best_ff);
               rsp_in.moved          = (best_ff != oldc_ff);
               rsp_in.new_total      = OUT_W'(new_tot);
               rsp_in.new_internal   = OUT_W'(new_int);
               rsp_in.tally_overflow = ovf_ff;
               rsp_valid_in = 1'b1;
               tctl.clear   = 1'b1;
               ovf_in       = 1'b0;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tw_ff        <= TW_RESET;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         tw_ff        <= tw_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      n_ff    <= n_in;
      deg_ff  <= deg_in;
      self_ff <= self_in;
      last_ff <= last_in;
      oldc_ff <= oldc_in;
      best_ff <= best_in;
      c_ff    <= c_in;
      have_ff <= have_in;
      bg_ff   <= bg_in;
      p_ff    <= p_in;
      q_ff    <= q_in;
      bl_ff   <= bl_in;
      lo_ff   <= lo_in;
      cnt_ff  <= cnt_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

// ===== hdl/cme_checker.sv =====
// Port-level checks for the community move engine, bound to the top level.
// Depends on cme_pkg and community_move_engine_core.
`default_nettype none
module cme_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        req_valid,
   input wire logic                        req_stall,
   input wire cme_pkg::req_type            req_data,
   input wire logic                        rsp_valid,
   input wire logic                        rsp_stall,
   input wire cme_pkg::rsp_type            rsp_data,
   input wire logic                        csr_wr_en,
   input wire logic [cme_pkg::TW_BITS-1:0] csr_wr_data
);
   import cme_pkg::*;

   // a held response keeps its contents
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // moved flag agrees with the two community ids
   a_moved: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.moved == (rsp_data.new_community != rsp_data.old_community))
      else $error("moved flag inconsistent");

   // no response out of reset
   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // an init request never produces a response
   a_init_quiet: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.command == CMD_INIT) |=> !$rose(rsp_valid))
      else $error("response after init request");

endmodule

bind community_move_engine_core cme_checker u_cme_checker (.*);
`default_nettype wire
